### hw/rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies; used by the top level by scoped names.
package ffba_pkg;

   localparam int START_W = 7;   // width of a start index field
   localparam int LEN_W   = 8;   // width of a run length field

   localparam logic FUNC_MARK  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_WRITE = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

endpackage

### hw/rtl/first_fit_block_allocator.sv
// First-fit allocator over a one-bit occupancy map held in a RAM.
// Depends on ffba_pkg and ffba_ram.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | func, mark_value, seg_start, run_length
//   rsp     | out       | rsp_valid/rsp_stall | found, alloc_start
//
// After reset a clearing pass writes every cell free while req is stalled.
// A mark word writes one cell a cycle through the single RAM write port.
// An allocate word scans one cell per cycle through the registered RAM read;
// on success the found run is then marked busy in the map.
// Synchronous active-high reset; a waiting response does not block the next word.
module first_fit_block_allocator #(
   parameter int CELLS = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic       req_mark_value,
   input  logic [6:0] req_seg_start,
   input  logic [7:0] req_run_length,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_found,
   output logic [6:0] rsp_alloc_start
);

   localparam int AW = $clog2(CELLS);
   localparam int CW = (AW + 1 > ffba_pkg::LEN_W) ? AW + 1 : ffba_pkg::LEN_W;
   localparam int PW = CW + 1;
   localparam logic [PW-1:0] CELLS_P = PW'(CELLS);
   localparam logic [PW-1:0] LAST_P  = PW'(CELLS - 1);

   ffba_pkg::state_type state_ff, state_in;

   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] end_ff, end_in;
   logic [PW-1:0] chk_ff, chk_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] run_ff, run_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          mval_ff, mval_in;
   logic          res_found_ff, res_found_in;
   logic [ffba_pkg::START_W-1:0] res_start_ff, res_start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [ffba_pkg::START_W-1:0] rsp_start_ff, rsp_start_in;

   logic          mem_we;
   logic          mem_wdata;
   logic          mem_rdata;

   logic [PW-1:0] req_start_p;
   logic [PW-1:0] req_len_p;
   logic [PW-1:0] req_end_p;
   logic [CW-1:0] run_next;
   logic [PW-1:0] where_p;

   ffba_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (pos_ff[AW-1:0]),
      .wr_data (mem_wdata),
      .rd_addr (pos_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   assign req_start_p = PW'(req_seg_start);
   assign req_len_p   = PW'(req_run_length);
   assign req_end_p   = req_start_p + req_len_p;
   assign run_next    = run_ff + CW'(1);
   assign where_p     = chk_ff + PW'(1) - PW'(len_ff);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      chk_in       = chk_ff;
      len_in       = len_ff;
      run_in       = run_ff;
      rd_vld_in    = 1'b0;
      mval_in      = mval_ff;
      res_found_in = res_found_ff;
      res_start_in = res_start_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      mem_we       = 1'b0;
      mem_wdata    = mval_ff;

      case (state_ff)
         ffba_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = 1'b0;
            pos_in    = pos_ff + PW'(1);
            if (pos_ff == LAST_P) begin
               state_in = ffba_pkg::ST_IDLE;
            end
         end
         ffba_pkg::ST_IDLE: begin
            if (req_valid) begin
               res_found_in = 1'b1;
               res_start_in = '0;
               if (req_func == ffba_pkg::FUNC_ALLOC) begin
                  len_in = CW'(req_run_length);
                  if (req_run_length == '0 || req_len_p > CELLS_P) begin
                     res_found_in = 1'b0;
                     state_in     = ffba_pkg::ST_RESP;
                  end else begin
                     pos_in   = '0;
                     run_in   = '0;
                     state_in = ffba_pkg::ST_SCAN;
                  end
               end else begin
                  mval_in = req_mark_value;
                  pos_in  = req_start_p;
                  end_in  = (req_end_p > CELLS_P) ? CELLS_P : req_end_p;
                  if (req_start_p >= CELLS_P || req_run_length == '0) begin
                     state_in = ffba_pkg::ST_RESP;
                  end else begin
                     state_in = ffba_pkg::ST_WRITE;
                  end
               end
            end
         end
         ffba_pkg::ST_WRITE: begin
            mem_we = 1'b1;
            pos_in = pos_ff + PW'(1);
            if (pos_ff + PW'(1) == end_ff) begin
               state_in = ffba_pkg::ST_RESP;
            end
         end
         ffba_pkg::ST_SCAN: begin
            // issue the next read while the previous cell's data is checked
            if (pos_ff < CELLS_P) begin
               rd_vld_in = 1'b1;
               chk_in    = pos_ff;
               pos_in    = pos_ff + PW'(1);
            end
            if (rd_vld_ff) begin
               if (!mem_rdata && run_next == len_ff) begin
                  pos_in       = where_p;
                  end_in       = chk_ff + PW'(1);
                  mval_in      = 1'b1;
                  res_found_in = 1'b1;
                  res_start_in = where_p[ffba_pkg::START_W-1:0];
                  rd_vld_in    = 1'b0;
                  state_in     = ffba_pkg::ST_WRITE;
               end else begin
                  run_in = mem_rdata ? '0 : run_next;
                  if (chk_ff == LAST_P) begin
                     res_found_in = 1'b0;
                     res_start_in = '0;
                     state_in     = ffba_pkg::ST_RESP;
                  end
               end
            end
         end
         ffba_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_start_in = res_start_ff;
               state_in     = ffba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::ST_CLEAR;
         pos_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_ff       <= end_in;
      chk_ff       <= chk_in;
      len_ff       <= len_in;
      run_ff       <= run_in;
      mval_ff      <= mval_in;
      res_found_ff <= res_found_in;
      res_start_ff <= res_start_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign req_stall       = (state_ff != ffba_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_alloc_start = rsp_start_ff;

`ifndef SYNTHESIS
   a_fail_zero_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_alloc_start == '0))
      else $error("failed allocation reports nonzero start");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ffba_pkg::ST_IDLE))
      else $error("accepted word did not start processing");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffba_pkg::ST_SCAN) |-> !mem_we)
      else $error("map written during scan");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ffba_pkg::ST_RESP))
      else $error("response raised outside response state");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (pos_ff < CELLS_P))
      else $error("map write beyond last cell");
`endif

endmodule

### hw/rtl/ffba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ffba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### test/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps
// Testbench for first_fit_block_allocator: directed and random mark/allocate words,
// each reply checked against an occupancy map kept in the bench.
// Depends on ffba_pkg and the allocator RTL.
module tb_first_fit_block_allocator;

   localparam int CELLS        = 128;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 300;
   localparam int PHASE_WORDS  = 325;
   localparam int START_W      = ffba_pkg::START_W;
   localparam int LEN_W        = ffba_pkg::LEN_W;

   typedef struct packed {
      logic               func;
      logic               mark_value;
      logic [START_W-1:0] seg_start;
      logic [LEN_W-1:0]   run_length;
   } alloc_word_type;

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] alloc_start;
   } alloc_reply_type;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_func        = ffba_pkg::FUNC_MARK;
   logic               req_mark_value  = 1'b0;
   logic [START_W-1:0] req_seg_start   = '0;
   logic [LEN_W-1:0]   req_run_length  = '0;
   logic               rsp_stall       = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic               rsp_found;
   logic [START_W-1:0] rsp_alloc_start;

   alloc_word_type  pending_words[$];
   alloc_reply_type predicted_replies[$];
   logic [CELLS-1:0] cell_busy = '0;

   logic req_taken    = 1'b0;
   int   quiet_cycles = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   words_queued = 0;
   int   words_accepted = 0;
   int   replies_checked = 0;
   int   errors = 0;
   int   grants = 0;
   int   refusals = 0;
   int   marks = 0;

   first_fit_block_allocator #(.CELLS(CELLS)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_mark_value  (req_mark_value),
      .req_seg_start   (req_seg_start),
      .req_run_length  (req_run_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_alloc_start (rsp_alloc_start)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void write_cells(int unsigned first, int unsigned len, logic v);
      for (int unsigned i = first; i < CELLS && i < first + len; i++)
         cell_busy[i] = v;
   endfunction

   // Updates the map for one accepted word and returns the reply it must produce.
   function automatic alloc_reply_type apply_word(alloc_word_type w);
      alloc_reply_type r;
      int unsigned     run;
      int unsigned     len;
      bit              hit;
      r    = '0;
      run  = 0;
      hit  = 0;
      len  = 32'(w.run_length);
      if (w.func == ffba_pkg::FUNC_MARK) begin
         write_cells(32'(w.seg_start), len, w.mark_value);
         r.found = 1'b1;
         marks++;
         return r;
      end
      if (len != 0 && len <= CELLS) begin
         for (int unsigned i = 0; i < CELLS && !hit; i++) begin
            if (!cell_busy[i]) begin
               run++;
               if (run == len) begin
                  hit           = 1;
                  r.alloc_start = START_W'(i + 1 - len);
               end
            end else begin
               run = 0;
            end
         end
      end
      if (hit) begin
         r.found = 1'b1;
         write_cells(32'(r.alloc_start), len, 1'b1);
         grants++;
      end else begin
         refusals++;
      end
      return r;
   endfunction

   function automatic void queue_word(logic f, logic v, int unsigned s, int unsigned l);
      alloc_word_type w;
      w.func       = f;
      w.mark_value = v;
      w.seg_start  = START_W'(s);
      w.run_length = LEN_W'(l);
      pending_words.push_back(w);
      words_queued++;
   endfunction

   // Driver: new word or idle at the falling edge, once the current word is taken.
   always @(negedge clock) begin : driver
      alloc_word_type w;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            w = pending_words.pop_front();
            req_valid      <= 1'b1;
            req_func       <= w.func;
            req_mark_value <= w.mark_value;
            req_seg_start  <= w.seg_start;
            req_run_length <= w.run_length;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Monitor: predict on request accept, compare on reply accept.
   always @(posedge clock) begin : monitor
      alloc_reply_type got;
      alloc_reply_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predicted_replies.push_back(
               apply_word({req_func, req_mark_value, req_seg_start, req_run_length}));
            words_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_found, rsp_alloc_start};
            if (predicted_replies.size() == 0) begin
               $display("%0t: reply with none expected, got found=%0b start=%0d",
                        $time, got.found, got.alloc_start);
               errors++;
            end else begin
               want = predicted_replies.pop_front();
               replies_checked++;
               if (got.found !== want.found) begin
                  $display("%0t: found mismatch, expected %0b, got %0b",
                           $time, want.found, got.found);
                  errors++;
               end
               if (got.alloc_start !== want.alloc_start) begin
                  $display("%0t: alloc_start mismatch, expected %0d, got %0d",
                           $time, want.alloc_start, got.alloc_start);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int          send_pct[4];
      int          stall_pct[4];
      int unsigned pick;
      int unsigned len;
      send_pct  = '{0, 87, 0, 28};
      stall_pct = '{0, 0, 87, 28};

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // empty map: zero length, whole map, then full map
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b0, 0, 0);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b1, 0, 128);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b0, 0, 1);
      // mark that runs off the map end frees only the last cell
      queue_word(ffba_pkg::FUNC_MARK,  1'b0, 127, 128);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b0, 0, 1);
      queue_word(ffba_pkg::FUNC_MARK,  1'b0, 0, 128);
      queue_word(ffba_pkg::FUNC_MARK,  1'b1, 0, 0);
      queue_word(ffba_pkg::FUNC_MARK,  1'b1, 1, 1);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b1, 0, 1);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b0, 0, 2);
      queue_word(ffba_pkg::FUNC_MARK,  1'b1, 64, 1);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b0, 0, 64);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b0, 0, 60);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b1, 0, 63);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b0, 0, 1);
      queue_word(ffba_pkg::FUNC_MARK,  1'b0, 0, 128);
      queue_word(ffba_pkg::FUNC_MARK,  1'b1, 127, 1);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b0, 127, 128);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b0, 85, 127);
      queue_word(ffba_pkg::FUNC_MARK,  1'b0, 42, 127);
      queue_word(ffba_pkg::FUNC_ALLOC, 1'b1, 0, 86);
      queue_word(ffba_pkg::FUNC_MARK,  1'b0, 0, 128);
      wait (words_accepted == words_queued);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pct[p];
         rsp_stall_pct = stall_pct[p];
         for (int n = 0; n < PHASE_WORDS; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               // mostly small allocations, some big ones, a few of zero length
               len = ($urandom_range(9) == 0) ? $urandom_range(17, 128)
                                              : $urandom_range(1, 16);
               if ($urandom_range(29) == 0)
                  len = 0;
               queue_word(ffba_pkg::FUNC_ALLOC, 1'($urandom_range(1)),
                          $urandom_range(127), len);
            end else if (pick < 75) begin
               queue_word(ffba_pkg::FUNC_MARK, 1'b0, $urandom_range(127),
                          $urandom_range(0, 32));
            end else if (pick < 90) begin
               queue_word(ffba_pkg::FUNC_MARK, 1'b1, $urandom_range(127),
                          $urandom_range(1, 16));
            end else if (pick < 95) begin
               queue_word(ffba_pkg::FUNC_MARK, 1'b0, 0, 128);
            end else begin
               queue_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                          $urandom_range(127), $urandom_range(128));
            end
         end
         wait (words_accepted == words_queued);
      end

      wait (replies_checked == words_accepted);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d words over four handshake phases:", words_accepted);
      $display("summary: %0d marks, %0d grants, %0d refusals, %0d replies checked",
               marks, grants, refusals, replies_checked);
      if (errors == 0 && predicted_replies.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### files.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ram.sv
hw/rtl/first_fit_block_allocator.sv
test/tb_first_fit_block_allocator.sv
